// ----- design/bku_pkg.sv -----
package bku_pkg;

	localparam int POS_W      = 20;
	localparam int VEL_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WORLD_WIDTH  = 3'd0,
		CFG_WORLD_HEIGHT = 3'd1,
		CFG_MAX_SPEED    = 3'd2,
		CFG_STEER_GAIN   = 3'd3,
		CFG_SENSOR_REACH = 3'd4
	} cfg_index_t;

	localparam logic [11:0] WORLD_WIDTH_RST  = 12'd800;
	localparam logic [11:0] WORLD_HEIGHT_RST = 12'd600;
	localparam logic [14:0] MAX_SPEED_RST    = 15'd1024;
	localparam logic [15:0] STEER_GAIN_RST   = 16'd6554;
	localparam logic [11:0] SENSOR_REACH_RST = 12'd100;

endpackage

// ----- design/bku_isqrt.sv -----
module bku_isqrt #(
	parameter int IW = 34,
	parameter int TW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [IW-1:0]   in_radicand,
	input  logic [TW-1:0]   in_tag,
	output logic            out_valid,
	output logic [IW/2-1:0] out_root,
	output logic [TW-1:0]   out_tag
);

	localparam int N  = IW / 2;
	localparam int RW = N + 2;

	logic            vld_s  [N+1];
	logic [IW-1:0]   x_s    [N+1];
	logic [RW-1:0]   rem_s  [N+1];
	logic [N-1:0]    root_s [N+1];
	logic [TW-1:0]   tag_s  [N+1];

	assign vld_s[0]  = in_valid;
	assign x_s[0]    = in_radicand;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign tag_s[0]  = in_tag;

	// one result bit per stage, two radicand bits consumed each time
	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] trial;
		logic          ge;

		always_comb begin
			rem_sh = {rem_s[k][RW-3:0], x_s[k][IW-1 -: 2]};
			trial  = {root_s[k], 2'b01};
			ge     = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			x_s[k+1]    <= x_s[k] << 2;
			rem_s[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
			root_s[k+1] <= {root_s[k][N-2:0], ge};
			tag_s[k+1]  <= tag_s[k];
		end
	end

	assign out_valid = vld_s[N];
	assign out_root  = root_s[N];
	assign out_tag   = tag_s[N];

endmodule

// ----- design/bku_div.sv -----
module bku_div #(
	parameter int NW = 33,
	parameter int DW = 17,
	parameter int QW = 15,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [QW-1:0] out_quot,
	output logic [TW-1:0] out_tag
);

	// numerator is known to stay below den << QW
	localparam int CW = DW + QW;

	logic          vld_s [QW+1];
	logic [CW-1:0] r_s   [QW+1];
	logic [DW-1:0] d_s   [QW+1];
	logic [QW-1:0] q_s   [QW+1];
	logic [TW-1:0] tag_s [QW+1];

	assign vld_s[0] = in_valid;
	assign r_s[0]   = CW'(in_num);
	assign d_s[0]   = in_den;
	assign q_s[0]   = '0;
	assign tag_s[0] = in_tag;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int J = QW - 1 - k;
		logic [CW-1:0] dsh;
		logic          ge;

		always_comb begin
			dsh = CW'(d_s[k]) << J;
			ge  = (r_s[k] >= dsh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			r_s[k+1]   <= ge ? (r_s[k] - dsh) : r_s[k];
			d_s[k+1]   <= d_s[k];
			q_s[k+1]   <= (q_s[k] << 1) | QW'(ge);
			tag_s[k+1] <= tag_s[k];
		end
	end

	assign out_valid = vld_s[QW];
	assign out_quot  = q_s[QW];
	assign out_tag   = tag_s[QW];

endmodule

// ----- design/boid_kinematic_update.sv -----
// Fully pipelined agent update: one request may be issued on every clock
// cycle and each result appears on the outputs, marked by done for a single
// cycle. The depth is set by two bit-serial square-root pipelines (17 and
// 16 stages) and two restoring divider pipelines (15 and 12 + FRAC_BITS
// stages) in sequence. The receiver cannot stall the block; busy is high only
// during reset and the first cycle after it. Registers are written through
// wr_en/wr_index/wr_data and should change only while no request is in
// flight.
module boid_kinematic_update #(
	parameter int FRAC_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [bku_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [bku_pkg::CFG_DATA_W-1:0]      wr_data,
	input  logic                                start,
	output logic                                busy,
	input  logic [bku_pkg::POS_W-1:0]           pos_x,
	input  logic [bku_pkg::POS_W-1:0]           pos_y,
	input  logic signed [bku_pkg::VEL_W-1:0]    vel_x,
	input  logic signed [bku_pkg::VEL_W-1:0]    vel_y,
	input  logic signed [bku_pkg::VEL_W-1:0]    steer_x,
	input  logic signed [bku_pkg::VEL_W-1:0]    steer_y,
	output logic                                done,
	output logic [bku_pkg::POS_W-1:0]           new_pos_x,
	output logic [bku_pkg::POS_W-1:0]           new_pos_y,
	output logic signed [bku_pkg::VEL_W-1:0]    new_vel_x,
	output logic signed [bku_pkg::VEL_W-1:0]    new_vel_y,
	output logic [bku_pkg::POS_W-1:0]           look_x,
	output logic [bku_pkg::POS_W-1:0]           look_y,
	output logic                                speed_limited
);

	localparam int RW  = 12 + FRAC_BITS;
	localparam int PW  = ((RW > bku_pkg::POS_W) ? RW : bku_pkg::POS_W) + 3;
	localparam int NW2 = RW + 17;

	typedef struct packed {
		logic               limited;
		logic signed [17:0] vx;
		logic signed [17:0] vy;
		logic [19:0]        px;
		logic [19:0]        py;
	} tag1_t;

	typedef struct packed {
		logic        limited;
		logic        m_zero;
		logic        neg;
		logic [15:0] v;
		logic [19:0] px;
		logic [19:0] py;
	} tag_dx_t;

	typedef struct packed {
		logic        neg;
		logic [15:0] v;
	} tag_dy_t;

	typedef struct packed {
		logic                limited;
		logic signed [15:0]  vx;
		logic signed [15:0]  vy;
		logic signed [PW-1:0] px;
		logic signed [PW-1:0] py;
	} tag2_t;

	typedef struct packed {
		logic                 limited;
		logic                 m_zero;
		logic                 neg;
		logic signed [15:0]   vx;
		logic signed [15:0]   vy;
		logic signed [PW-1:0] px;
		logic signed [PW-1:0] py;
	} tag_ex_t;

	function automatic logic signed [17:0] round_gain(input logic signed [32:0] p);
		logic [32:0] mag;
		logic [16:0] q;
		mag = p[32] ? 33'(-p) : 33'(p);
		q   = 17'((mag + 33'd32768) >> 16);
		return p[32] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	function automatic logic [16:0] abs18(input logic signed [17:0] v);
		return v[17] ? 17'(-v) : 17'(v);
	endfunction

	function automatic logic [15:0] abs16(input logic signed [15:0] v);
		return v[15] ? 16'(-v) : 16'(v);
	endfunction

	function automatic logic signed [PW-1:0] wrap_once(input logic signed [PW-1:0] p,
			input logic [RW-1:0] period);
		logic signed [PW-1:0] pp;
		logic signed [PW-1:0] r;
		pp = $signed(PW'(period));
		priority if (p < 0) begin
			r = p + pp;
		end else if (p >= pp) begin
			r = p - pp;
		end else begin
			r = p;
		end
		return r;
	endfunction

	// configuration
	logic [11:0] world_width_q;
	logic [11:0] world_height_q;
	logic [14:0] max_speed_q;
	logic [15:0] steer_gain_q;
	logic [11:0] sensor_reach_q;
	logic        busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			world_width_q  <= bku_pkg::WORLD_WIDTH_RST;
			world_height_q <= bku_pkg::WORLD_HEIGHT_RST;
			max_speed_q    <= bku_pkg::MAX_SPEED_RST;
			steer_gain_q   <= bku_pkg::STEER_GAIN_RST;
			sensor_reach_q <= bku_pkg::SENSOR_REACH_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				bku_pkg::CFG_WORLD_WIDTH:  world_width_q  <= wr_data[11:0];
				bku_pkg::CFG_WORLD_HEIGHT: world_height_q <= wr_data[11:0];
				bku_pkg::CFG_MAX_SPEED:    max_speed_q    <= wr_data[14:0];
				bku_pkg::CFG_STEER_GAIN:   steer_gain_q   <= wr_data[15:0];
				bku_pkg::CFG_SENSOR_REACH: sensor_reach_q <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	logic [RW-1:0] w_period;
	logic [RW-1:0] h_period;
	logic [RW-1:0] reach_fix;

	assign w_period  = {world_width_q, {FRAC_BITS{1'b0}}};
	assign h_period  = {world_height_q, {FRAC_BITS{1'b0}}};
	assign reach_fix = {sensor_reach_q, {FRAC_BITS{1'b0}}};

	// stage 1: steering times gain
	logic               valid_s1;
	logic [19:0]        px_s1, py_s1;
	logic signed [15:0] vx_s1, vy_s1;
	logic signed [32:0] gx_s1, gy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= pos_x;
		py_s1 <= pos_y;
		vx_s1 <= vel_x;
		vy_s1 <= vel_y;
		gx_s1 <= $signed(steer_x) * $signed({1'b0, steer_gain_q});
		gy_s1 <= $signed(steer_y) * $signed({1'b0, steer_gain_q});
	end

	// stage 2: velocity plus rounded steering
	logic               valid_s2;
	logic [19:0]        px_s2, py_s2;
	logic signed [17:0] vx_s2, vy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		px_s2 <= px_s1;
		py_s2 <= py_s1;
		vx_s2 <= 18'(vx_s1) + round_gain(gx_s1);
		vy_s2 <= 18'(vy_s1) + round_gain(gy_s1);
	end

	// stage 3: squares
	logic               valid_s3;
	logic [19:0]        px_s3, py_s3;
	logic signed [17:0] vx_s3, vy_s3;
	logic [32:0]        sqx_s3, sqy_s3;
	logic [29:0]        vmax_sq_s3;
	logic signed [35:0] sqx_full, sqy_full;

	always_comb begin
		sqx_full = vx_s2 * vx_s2;
		sqy_full = vy_s2 * vy_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		px_s3      <= px_s2;
		py_s3      <= py_s2;
		vx_s3      <= vx_s2;
		vy_s3      <= vy_s2;
		sqx_s3     <= 33'(sqx_full);
		sqy_s3     <= 33'(sqy_full);
		vmax_sq_s3 <= max_speed_q * max_speed_q;
	end

	// stage 4: squared speed and limit test
	logic        valid_s4;
	logic [33:0] lsq_s4;
	tag1_t       t_s4;
	logic [33:0] lsq_nx;

	assign lsq_nx = 34'(sqx_s3) + 34'(sqy_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		lsq_s4       <= lsq_nx;
		t_s4.limited <= (lsq_nx >= 34'(vmax_sq_s3));
		t_s4.vx      <= vx_s3;
		t_s4.vy      <= vy_s3;
		t_s4.px      <= px_s3;
		t_s4.py      <= py_s3;
	end

	logic        sq1_valid;
	logic [16:0] sq1_root;
	tag1_t       sq1_tag;

	bku_isqrt #(
		.IW (34),
		.TW ($bits(tag1_t))
	) u_sqrt_speed (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_s4),
		.in_radicand (lsq_s4),
		.in_tag      (t_s4),
		.out_valid   (sq1_valid),
		.out_root    (sq1_root),
		.out_tag     (sq1_tag)
	);

	// stage 5: |v| times limit
	logic        valid_s5;
	logic [31:0] numx_s5, numy_s5;
	logic [16:0] m_s5;
	tag1_t       t_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= sq1_valid;
		end
	end

	always_ff @(posedge clk) begin
		numx_s5 <= abs18(sq1_tag.vx) * max_speed_q;
		numy_s5 <= abs18(sq1_tag.vy) * max_speed_q;
		m_s5    <= sq1_root;
		t_s5    <= sq1_tag;
	end

	// stage 6: add half divisor for rounding
	logic        valid_s6;
	logic [32:0] nx_s6, ny_s6;
	logic [16:0] m_s6;
	tag1_t       t_s6;
	tag_dx_t     dx_in;
	tag_dy_t     dy_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		nx_s6 <= 33'(numx_s5) + 33'(m_s5 >> 1);
		ny_s6 <= 33'(numy_s5) + 33'(m_s5 >> 1);
		m_s6  <= m_s5;
		t_s6  <= t_s5;
	end

	always_comb begin
		dx_in.limited = t_s6.limited;
		dx_in.m_zero  = (m_s6 == '0);
		dx_in.neg     = t_s6.vx[17];
		dx_in.v       = t_s6.vx[15:0];
		dx_in.px      = t_s6.px;
		dx_in.py      = t_s6.py;
		dy_in.neg     = t_s6.vy[17];
		dy_in.v       = t_s6.vy[15:0];
	end

	logic        dvx_valid, dvy_valid;
	logic [14:0] qx1, qy1;
	tag_dx_t     dx_out;
	tag_dy_t     dy_out;

	bku_div #(
		.NW (33),
		.DW (17),
		.QW (15),
		.TW ($bits(tag_dx_t))
	) u_div_vx (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s6),
		.in_num    (nx_s6),
		.in_den    (m_s6),
		.in_tag    (dx_in),
		.out_valid (dvx_valid),
		.out_quot  (qx1),
		.out_tag   (dx_out)
	);

	bku_div #(
		.NW (33),
		.DW (17),
		.QW (15),
		.TW ($bits(tag_dy_t))
	) u_div_vy (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s6),
		.in_num    (ny_s6),
		.in_den    (m_s6),
		.in_tag    (dy_in),
		.out_valid (dvy_valid),
		.out_quot  (qy1),
		.out_tag   (dy_out)
	);

	// stage 7: final velocity
	logic               valid_s7;
	logic               lim_s7;
	logic signed [15:0] vfx_s7, vfy_s7;
	logic [19:0]        px_s7, py_s7;
	logic signed [15:0] vfx_nx, vfy_nx;

	always_comb begin
		priority if (!dx_out.limited) begin
			vfx_nx = $signed(dx_out.v);
			vfy_nx = $signed(dy_out.v);
		end else if (dx_out.m_zero) begin
			vfx_nx = '0;
			vfy_nx = '0;
		end else begin
			vfx_nx = dx_out.neg ? -$signed({1'b0, qx1}) : $signed({1'b0, qx1});
			vfy_nx = dy_out.neg ? -$signed({1'b0, qy1}) : $signed({1'b0, qy1});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= dvx_valid && dvy_valid;
		end
	end

	always_ff @(posedge clk) begin
		lim_s7 <= dx_out.limited;
		vfx_s7 <= vfx_nx;
		vfy_s7 <= vfy_nx;
		px_s7  <= dx_out.px;
		py_s7  <= dx_out.py;
	end

	// stage 8: squares of final velocity, raw new position
	logic                 valid_s8;
	logic                 lim_s8;
	logic signed [15:0]   vfx_s8, vfy_s8;
	logic [30:0]          sq2x_s8, sq2y_s8;
	logic signed [PW-1:0] psx_s8, psy_s8;
	logic signed [31:0]   sq2x_full, sq2y_full;

	always_comb begin
		sq2x_full = vfx_s7 * vfx_s7;
		sq2y_full = vfy_s7 * vfy_s7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		lim_s8  <= lim_s7;
		vfx_s8  <= vfx_s7;
		vfy_s8  <= vfy_s7;
		sq2x_s8 <= 31'(sq2x_full);
		sq2y_s8 <= 31'(sq2y_full);
		psx_s8  <= $signed(PW'(px_s7)) + PW'(vfx_s7);
		psy_s8  <= $signed(PW'(py_s7)) + PW'(vfy_s7);
	end

	// stage 9: squared speed, wrapped position
	logic        valid_s9;
	logic [31:0] l2_s9;
	tag2_t       t_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else begin
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		l2_s9        <= 32'(sq2x_s8) + 32'(sq2y_s8);
		t_s9.limited <= lim_s8;
		t_s9.vx      <= vfx_s8;
		t_s9.vy      <= vfy_s8;
		t_s9.px      <= wrap_once(psx_s8, w_period);
		t_s9.py      <= wrap_once(psy_s8, h_period);
	end

	logic        sq2_valid;
	logic [15:0] sq2_root;
	tag2_t       sq2_tag;

	bku_isqrt #(
		.IW (32),
		.TW ($bits(tag2_t))
	) u_sqrt_heading (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_s9),
		.in_radicand (l2_s9),
		.in_tag      (t_s9),
		.out_valid   (sq2_valid),
		.out_root    (sq2_root),
		.out_tag     (sq2_tag)
	);

	// stage 10: reach times |v|
	logic           valid_s10;
	logic [RW+15:0] n2x_s10, n2y_s10;
	logic [15:0]    m2_s10;
	tag2_t          t_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else begin
			valid_s10 <= sq2_valid;
		end
	end

	always_ff @(posedge clk) begin
		n2x_s10 <= abs16(sq2_tag.vx) * reach_fix;
		n2y_s10 <= abs16(sq2_tag.vy) * reach_fix;
		m2_s10  <= sq2_root;
		t_s10   <= sq2_tag;
	end

	// stage 11: add half divisor
	logic           valid_s11;
	logic [NW2-1:0] n2x_s11, n2y_s11;
	logic [15:0]    m2_s11;
	tag2_t          t_s11;
	tag_ex_t        ex_in;
	logic           ey_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
		end else begin
			valid_s11 <= valid_s10;
		end
	end

	always_ff @(posedge clk) begin
		n2x_s11 <= NW2'(n2x_s10) + NW2'(m2_s10 >> 1);
		n2y_s11 <= NW2'(n2y_s10) + NW2'(m2_s10 >> 1);
		m2_s11  <= m2_s10;
		t_s11   <= t_s10;
	end

	always_comb begin
		ex_in.limited = t_s11.limited;
		ex_in.m_zero  = (m2_s11 == '0);
		ex_in.neg     = t_s11.vx[15];
		ex_in.vx      = t_s11.vx;
		ex_in.vy      = t_s11.vy;
		ex_in.px      = t_s11.px;
		ex_in.py      = t_s11.py;
		ey_in         = t_s11.vy[15];
	end

	logic          dlx_valid, dly_valid;
	logic [RW-1:0] qx2, qy2;
	tag_ex_t       ex_out;
	logic          ey_out;

	bku_div #(
		.NW (NW2),
		.DW (16),
		.QW (RW),
		.TW ($bits(tag_ex_t))
	) u_div_lx (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s11),
		.in_num    (n2x_s11),
		.in_den    (m2_s11),
		.in_tag    (ex_in),
		.out_valid (dlx_valid),
		.out_quot  (qx2),
		.out_tag   (ex_out)
	);

	bku_div #(
		.NW (NW2),
		.DW (16),
		.QW (RW),
		.TW (1)
	) u_div_ly (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s11),
		.in_num    (n2y_s11),
		.in_den    (m2_s11),
		.in_tag    (ey_in),
		.out_valid (dly_valid),
		.out_quot  (qy2),
		.out_tag   (ey_out)
	);

	// stage 12: look-ahead sums, zero heading points to +y
	logic                 valid_s12;
	logic                 lim_s12;
	logic signed [15:0]   vx_s12, vy_s12;
	logic signed [PW-1:0] px_s12, py_s12;
	logic signed [PW-1:0] lx_s12, ly_s12;
	logic signed [PW-1:0] offx, offy;

	always_comb begin
		if (ex_out.m_zero) begin
			offx = '0;
			offy = $signed(PW'(reach_fix));
		end else begin
			offx = ex_out.neg ? -$signed(PW'(qx2)) : $signed(PW'(qx2));
			offy = ey_out ? -$signed(PW'(qy2)) : $signed(PW'(qy2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s12 <= 1'b0;
		end else begin
			valid_s12 <= dlx_valid && dly_valid;
		end
	end

	always_ff @(posedge clk) begin
		lim_s12 <= ex_out.limited;
		vx_s12  <= ex_out.vx;
		vy_s12  <= ex_out.vy;
		px_s12  <= ex_out.px;
		py_s12  <= ex_out.py;
		lx_s12  <= ex_out.px + offx;
		ly_s12  <= ex_out.py + offy;
	end

	// output register
	logic signed [PW-1:0] lxw, lyw;

	always_comb begin
		lxw = wrap_once(lx_s12, w_period);
		lyw = wrap_once(ly_s12, h_period);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s12;
		end
	end

	always_ff @(posedge clk) begin
		new_pos_x     <= px_s12[bku_pkg::POS_W-1:0];
		new_pos_y     <= py_s12[bku_pkg::POS_W-1:0];
		new_vel_x     <= vx_s12;
		new_vel_y     <= vy_s12;
		look_x        <= lxw[bku_pkg::POS_W-1:0];
		look_y        <= lyw[bku_pkg::POS_W-1:0];
		speed_limited <= lim_s12;
	end

endmodule

// ----- design/bku_checker.sv -----
module bku_sva #(
	parameter int FRAC_BITS = 8
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic signed [bku_pkg::VEL_W-1:0] vel_x,
	input logic signed [bku_pkg::VEL_W-1:0] vel_y,
	input logic signed [bku_pkg::VEL_W-1:0] steer_x,
	input logic signed [bku_pkg::VEL_W-1:0] steer_y,
	input logic signed [bku_pkg::VEL_W-1:0] new_vel_x,
	input logic signed [bku_pkg::VEL_W-1:0] new_vel_y,
	input logic                             speed_limited
);

	localparam int LAT = 73 + FRAC_BITS;
	localparam int LIM = LAT + 1;
	localparam int CNT_W = $clog2(LIM + 1);

	logic [CNT_W-1:0] since_q;

	// cycles since reset, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q <= '0;
		end else if (since_q != CNT_W'(LIM)) begin
			since_q <= since_q + 1'b1;
		end
	end

	a_done_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching request");

	a_request_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(since_q == CNT_W'(LIM)) && $past(start && !busy, LAT) |-> done)
		else $error("request lost in the pipeline");

	a_vel_x_kept: assert property (@(posedge clk) disable iff (!arst_n)
		done && !speed_limited && $past(steer_x == '0, LAT)
		|-> new_vel_x == $past(vel_x, LAT))
		else $error("unlimited x velocity changed without steering");

	a_vel_y_kept: assert property (@(posedge clk) disable iff (!arst_n)
		done && !speed_limited && $past(steer_y == '0, LAT)
		|-> new_vel_y == $past(vel_y, LAT))
		else $error("unlimited y velocity changed without steering");

endmodule

bind boid_kinematic_update bku_sva #(.FRAC_BITS(FRAC_BITS)) u_bku_sva (.*);

// ----- tb/bku_checker.sv -----
module bku_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [bku_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [bku_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic        start,
	input  logic        busy,
	input  logic [19:0] pos_x,
	input  logic [19:0] pos_y,
	input  logic [15:0] vel_x,
	input  logic [15:0] vel_y,
	input  logic [15:0] steer_x,
	input  logic [15:0] steer_y,
	input  logic        done,
	input  logic [19:0] new_pos_x,
	input  logic [19:0] new_pos_y,
	input  logic [15:0] new_vel_x,
	input  logic [15:0] new_vel_y,
	input  logic [19:0] look_x,
	input  logic [19:0] look_y,
	input  logic        speed_limited,
	output int          pending,
	output int          fail_count
);

	localparam int FRAC = 8;

	typedef struct packed {
		logic [19:0] px;
		logic [19:0] py;
		logic [15:0] vx;
		logic [15:0] vy;
		logic [19:0] lx;
		logic [19:0] ly;
		logic        lim;
	} agent_out_t;

	logic [11:0] width_q, height_q, reach_q;
	logic [14:0] vmax_q;
	logic [15:0] gain_q;
	agent_out_t  update_q[$];

	function automatic longint rnd_div(longint n, longint d);
		longint un;
		longint q;
		un = (n < 0) ? -n : n;
		q  = (un + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic longint floor_sqrt(longint x);
		longint r;
		longint b;
		r = 0;
		b = longint'(1) <<< 62;
		while (b > x) b = b >>> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint wrap_torus(longint p, longint period);
		if (p < 0)
			return p + period;
		if (p >= period)
			return p - period;
		return p;
	endfunction

	function automatic agent_out_t predict_agent(logic [19:0] ipx, logic [19:0] ipy,
			logic signed [15:0] ivx, logic signed [15:0] ivy,
			logic signed [15:0] isx, logic signed [15:0] isy);
		longint px, py, vx, vy, wp, hp, reach, vmax, lsq, m, lx, ly;
		agent_out_t r;
		px    = ipx;
		py    = ipy;
		vmax  = vmax_q;
		wp    = longint'(width_q) <<< FRAC;
		hp    = longint'(height_q) <<< FRAC;
		reach = longint'(reach_q) <<< FRAC;
		vx = longint'(ivx) + rnd_div(longint'(isx) * gain_q, 65536);
		vy = longint'(ivy) + rnd_div(longint'(isy) * gain_q, 65536);
		lsq = vx * vx + vy * vy;
		r.lim = 1'b0;
		if (lsq >= vmax * vmax) begin
			r.lim = 1'b1;
			m = floor_sqrt(lsq);
			if (m == 0) begin
				vx = 0;
				vy = 0;
			end else begin
				vx = rnd_div(vx * vmax, m);
				vy = rnd_div(vy * vmax, m);
			end
		end
		if (vx > 32767) vx = 32767;
		if (vx < -32768) vx = -32768;
		if (vy > 32767) vy = 32767;
		if (vy < -32768) vy = -32768;
		px = wrap_torus(px + vx, wp);
		py = wrap_torus(py + vy, hp);
		m = floor_sqrt(vx * vx + vy * vy);
		if (m == 0) begin
			lx = px;
			ly = py + reach;
		end else begin
			lx = px + rnd_div(reach * vx, m);
			ly = py + rnd_div(reach * vy, m);
		end
		r.px = px[19:0];
		r.py = py[19:0];
		r.vx = vx[15:0];
		r.vy = vy[15:0];
		r.lx = 20'(wrap_torus(lx, wp));
		r.ly = 20'(wrap_torus(ly, hp));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		agent_out_t got, want;
		if (!arst_n) begin
			width_q    <= bku_pkg::WORLD_WIDTH_RST;
			height_q   <= bku_pkg::WORLD_HEIGHT_RST;
			vmax_q     <= bku_pkg::MAX_SPEED_RST;
			gain_q     <= bku_pkg::STEER_GAIN_RST;
			reach_q    <= bku_pkg::SENSOR_REACH_RST;
			fail_count <= 0;
			pending    <= 0;
			update_q.delete();
		end else begin
			if (wr_en) begin
				case (bku_pkg::cfg_index_t'(wr_index))
					bku_pkg::CFG_WORLD_WIDTH:  width_q  <= wr_data[11:0];
					bku_pkg::CFG_WORLD_HEIGHT: height_q <= wr_data[11:0];
					bku_pkg::CFG_MAX_SPEED:    vmax_q   <= wr_data[14:0];
					bku_pkg::CFG_STEER_GAIN:   gain_q   <= wr_data;
					bku_pkg::CFG_SENSOR_REACH: reach_q  <= wr_data[11:0];
					default: ;
				endcase
			end
			if (start && !busy)
				update_q.push_back(predict_agent(pos_x, pos_y, vel_x, vel_y,
					steer_x, steer_y));
			if (done) begin
				got = '{new_pos_x, new_pos_y, new_vel_x, new_vel_y, look_x, look_y,
					speed_limited};
				if (update_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = update_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch: exp pos %h %h vel %h %h look %h %h lim %b,",
								want.px, want.py, want.vx, want.vy, want.lx, want.ly,
								want.lim,
								" got pos %h %h vel %h %h look %h %h lim %b",
								got.px, got.py, got.vx, got.vy, got.lx, got.ly, got.lim);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= update_q.size();
		end
	end

endmodule

// ----- tb/tb_boid_kinematic_update.sv -----
module tb_boid_kinematic_update;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [bku_pkg::CFG_IDX_W-1:0]  wr_index;
	logic [bku_pkg::CFG_DATA_W-1:0] wr_data;
	logic        start;
	logic        busy;
	logic [19:0] pos_x, pos_y;
	logic signed [15:0] vel_x, vel_y, steer_x, steer_y;
	logic        done;
	logic [19:0] new_pos_x, new_pos_y, look_x, look_y;
	logic signed [15:0] new_vel_x, new_vel_y;
	logic        speed_limited;
	int          pending;
	int          fail_count;
	int          idle_cycles;
	int          gap_pct;

	boid_kinematic_update dut (.*);

	bku_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog on cycles with no request or result
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_agent(logic [19:0] px, logic [19:0] py, logic [15:0] vx,
			logic [15:0] vy, logic [15:0] sx, logic [15:0] sy);
		while ($urandom_range(99, 0) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		pos_x   <= px;
		pos_y   <= py;
		vel_x   <= vx;
		vel_y   <= vy;
		steer_x <= sx;
		steer_y <= sy;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain_updates();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || done) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(bku_pkg::cfg_index_t idx, logic [15:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_world(int w, int h, int vmax, int gain, int reach);
		write_reg(bku_pkg::CFG_WORLD_WIDTH, 16'(w));
		write_reg(bku_pkg::CFG_WORLD_HEIGHT, 16'(h));
		write_reg(bku_pkg::CFG_MAX_SPEED, 16'(vmax));
		write_reg(bku_pkg::CFG_STEER_GAIN, 16'(gain));
		write_reg(bku_pkg::CFG_SENSOR_REACH, 16'(reach));
	endtask

	// mostly in-world positions and modest speeds, sometimes anything
	task automatic send_random_agent(int w, int h);
		logic [19:0] px, py;
		if ($urandom_range(9, 0) == 0) begin
			px = 20'($urandom);
			py = 20'($urandom);
		end else begin
			px = 20'($urandom_range(w * 256 - 1, 0));
			py = 20'($urandom_range(h * 256 - 1, 0));
		end
		if ($urandom_range(3, 0) == 0)
			send_agent(px, py, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom));
		else
			send_agent(px, py, 16'($urandom_range(4095, 0) - 2048),
				16'($urandom_range(4095, 0) - 2048),
				16'($urandom_range(2047, 0) - 1024),
				16'($urandom_range(2047, 0) - 1024));
	endtask

	initial begin
		int w, h;
		arst_n   = 1'b0;
		wr_en    = 1'b0;
		wr_index = '0;
		wr_data  = '0;
		start    = 1'b0;
		pos_x    = '0;
		pos_y    = '0;
		vel_x    = '0;
		vel_y    = '0;
		steer_x  = '0;
		steer_y  = '0;
		gap_pct  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero velocity, limiting, wrap both ways
		send_agent(20'd0, 20'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_agent(20'hFFFFF, 20'hFFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_agent(20'd0, 20'd0, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
		send_agent(20'd100, 20'd100, -16'sd300, -16'sd300, 16'sd0, 16'sd0);
		send_agent(20'd204700, 20'd153500, 16'sd600, 16'sd600, 16'sd0, 16'sd0);
		send_agent(20'd5000, 20'd5000, 16'sd1024, 16'sd0, 16'sd0, 16'sd0);
		send_agent(20'd5000, 20'd5000, 16'sd0, 16'sd1023, 16'sd0, 16'sd0);
		send_agent(20'd5000, 20'd5000, 16'sd3, -16'sd3, -16'sd30, 16'sd30);
		send_agent(20'd1000, 20'd1000, 16'sd100, 16'sd0, -16'sd1000, 16'sd0);
		drain_updates();

		// zero limit, zero world, zero gain and reach
		set_world(0, 0, 0, 0, 0);
		send_agent(20'd10, 20'd10, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_agent(20'd10, 20'd10, 16'sd5, -16'sd7, 16'sd9, 16'sd9);
		drain_updates();
		set_world(4095, 4095, 32767, 65535, 4095);
		send_agent(20'hFFFFF, 20'd0, 16'sh7FFF, -16'sd32768, 16'sh7FFF, -16'sd32768);
		send_agent(20'd0, 20'hFFFFF, -16'sd1, 16'sd1, -16'sd1, 16'sd1);
		send_agent(20'd12345, 20'd54321, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		drain_updates();

		for (int phase = 0; phase < 7; phase++) begin
			gap_pct = (phase < 2) ? 28 : (phase < 4) ? 83 : 0;
			w = (phase == 6) ? 1 : $urandom_range(4095, 1);
			h = (phase == 6) ? 1 : $urandom_range(4095, 1);
			set_world(w, h, (phase == 5) ? 1 : $urandom_range(4000, 1),
				$urandom_range(65535, 0), $urandom_range(4095, 0));
			for (int i = 0; i < 100; i++)
				send_random_agent(w, h);
			drain_updates();
		end

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
